FILE: hdl/iqam_pkg.sv
// Shared types and constants for the I/Q magnitude AM demodulator.
`timescale 1ns / 1ps

package iqam_pkg;

   localparam int SMP_W    = 16;               // input sample width
   localparam int MAG_W    = 15;               // halved magnitude / envelope width
   localparam int SQ_W     = 2 * MAG_W;        // width of one square and of the sum
   localparam int RAD_W    = 32;               // radicand register of the root unit
   localparam int ROOT_W   = 18;
   localparam int REM_W    = 21;
   localparam int SQ_STEPS = MAG_W;            // one multiplier bit per cycle
   localparam int RT_STEPS = RAD_W / 2;        // one result bit per cycle
   localparam int SQ_CNT_W = $clog2(SQ_STEPS);
   localparam int RT_CNT_W = $clog2(RT_STEPS);

   localparam logic [1:0] MODE_OFF  = 2'd0;
   localparam logic [1:0] MODE_FAST = 2'd1;

   localparam logic [1:0] PHASE_OUT = 2'd1;

   typedef struct packed {
      logic            done;
      logic [SQ_W-1:0] sum;
   } sq_result_type;

   typedef struct packed {
      logic             done;
      logic [MAG_W-1:0] root;
   } rt_result_type;

endpackage

FILE: hdl/iqam_square.sv
// Bit-serial shift-and-add unit that forms a*a + b*b.
`timescale 1ns / 1ps

module iqam_square
   import iqam_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [MAG_W-1:0]     a_mag,
   input  logic [MAG_W-1:0]     b_mag,
   output sq_result_type        result
);

   logic                busy_ff;
   logic                done_ff;
   logic [SQ_CNT_W-1:0] cnt_ff;
   logic [SQ_W-1:0]     mcand_a_ff, mcand_b_ff;
   logic [MAG_W-1:0]    mplier_a_ff, mplier_b_ff;
   logic [SQ_W-1:0]     acc_a_ff, acc_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == SQ_CNT_W'(SQ_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // multiplier consumed LSB first, multiplicand moves up one place per step
   always_ff @(posedge clock) begin
      if (start) begin
         mcand_a_ff  <= SQ_W'(a_mag);
         mcand_b_ff  <= SQ_W'(b_mag);
         mplier_a_ff <= a_mag;
         mplier_b_ff <= b_mag;
         acc_a_ff    <= '0;
         acc_b_ff    <= '0;
      end else if (busy_ff) begin
         acc_a_ff    <= acc_a_ff + (mplier_a_ff[0] ? mcand_a_ff : '0);
         acc_b_ff    <= acc_b_ff + (mplier_b_ff[0] ? mcand_b_ff : '0);
         mcand_a_ff  <= {mcand_a_ff[SQ_W-2:0], 1'b0};
         mcand_b_ff  <= {mcand_b_ff[SQ_W-2:0], 1'b0};
         mplier_a_ff <= {1'b0, mplier_a_ff[MAG_W-1:1]};
         mplier_b_ff <= {1'b0, mplier_b_ff[MAG_W-1:1]};
      end
   end

   // sum of two squares of 15-bit halves stays below 2^30
   assign result.done = done_ff;
   assign result.sum  = acc_a_ff + acc_b_ff;

endmodule

FILE: hdl/iqam_isqrt.sv
// Integer square root, one result bit per cycle (restoring digit recurrence).
`timescale 1ns / 1ps

module iqam_isqrt
   import iqam_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [SQ_W-1:0]      radicand,
   output rt_result_type        result
);

   logic                busy_ff;
   logic                done_ff;
   logic [RT_CNT_W-1:0] cnt_ff;
   logic [RAD_W-1:0]    rad_ff;
   logic [REM_W-1:0]    rem_ff;
   logic [ROOT_W-1:0]   root_ff;

   logic [REM_W-1:0]    rem_sh;
   logic [ROOT_W-1:0]   root_sh;
   logic                take;

   always_comb begin
      root_sh = {root_ff[ROOT_W-2:0], 1'b0};
      rem_sh  = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1:RAD_W-2]};
      take    = REM_W'(root_sh) < rem_sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == RT_CNT_W'(RT_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // root holds twice the partial root; a taken step subtracts 2r+1
   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= RAD_W'(radicand);
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff <= {rad_ff[RAD_W-3:0], 2'b00};
         if (take) begin
            rem_ff  <= rem_sh - REM_W'(root_sh) - 1'b1;
            root_ff <= root_sh + 2'd2;
         end else begin
            rem_ff  <= rem_sh;
            root_ff <= root_sh;
         end
      end
   end

   assign result.done = done_ff;
   assign result.root = root_ff[MAG_W:1];

endmodule

FILE: hdl/iq_magnitude_am_demodulator.sv
// Top level of the I/Q magnitude AM demodulator, magnitude on every fourth item.
`timescale 1ns / 1ps

// Usage:
//  req_* takes one I/Q pair per item; rsp_* returns one envelope item per
//  input item, except in mode 0, where input is consumed and nothing comes out.
//  A two-bit phase advances on every accepted item; the first item after reset
//  and every fourth one after it carry the magnitude, the rest carry zero.
//  csr_* writes the mode (0 off, 1 alpha-max/beta-min, 2 or 3 square root);
//  write it only while no item is in flight.
//  Zero items go from accept to S_OUT, then the output register; mode 1 items
//  pass S_FAST first. Mode 2 magnitude items: squarer load, 15 multiply steps,
//  root load, 16 root steps, result capture, then the output register.
//  The input takes one item at a time; req_tready is high only when idle.
//  Outside mode 0 the next accept waits until S_OUT hands the item to the output
//  register; mode 0 items are taken every cycle.
//  The output register holds a finished item while rsp_tready is low, and the
//  next input is still accepted; its result waits until the register frees.
//  Reset (synchronous, active high) clears the phase, the mode (to off), the
//  sequencer and the output valid.

module iq_magnitude_am_demodulator
   import iqam_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // config write: demod_mode
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_data,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // [15:0] i_sample, [31:16] q_sample
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata     // [14:0] envelope, [15] zero
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_FAST = 3'd1;
   localparam logic [2:0] S_SQ   = 3'd2;
   localparam logic [2:0] S_RT   = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [1:0]       mode_ff;
   logic [1:0]       phase_ff, phase_in;
   logic [MAG_W-1:0] a_ff, b_ff;
   logic [MAG_W-1:0] res_ff;
   logic             sq_start_ff;
   logic             rsp_tvalid_ff;
   logic [MAG_W-1:0] rsp_env_ff;

   logic             req_acc;
   logic             out_free;
   logic [SMP_W-1:0] i_half, q_half;
   logic [SMP_W-1:0] i_abs, q_abs;
   logic [MAG_W-1:0] hi, lo;
   logic [MAG_W+4:0] hi31;
   logic [MAG_W+1:0] lo3;
   logic [MAG_W:0]   fast_sum;

   sq_result_type    sq_res;
   rt_result_type    rt_res;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign phase_in   = phase_ff + 1'b1;

   // halve by arithmetic shift, then take the absolute value (max 16384)
   always_comb begin
      i_half = SMP_W'($signed(req_tdata[15:0]) >>> 1);
      q_half = SMP_W'($signed(req_tdata[31:16]) >>> 1);
      i_abs  = i_half[SMP_W-1] ? (~i_half + 1'b1) : i_half;
      q_abs  = q_half[SMP_W-1] ? (~q_half + 1'b1) : q_half;
   end

   // 31*max/32 + 3*min/8
   always_comb begin
      hi       = (a_ff > b_ff) ? a_ff : b_ff;
      lo       = (a_ff > b_ff) ? b_ff : a_ff;
      hi31     = {hi, 5'b0} - (MAG_W+5)'(hi);
      lo3      = {1'b0, lo, 1'b0} + (MAG_W+2)'(lo);
      fast_sum = (MAG_W+1)'(hi31[MAG_W+4:5]) + (MAG_W+1)'(lo3[MAG_W+1:3]);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_acc && mode_ff != MODE_OFF) begin
               if (phase_in != PHASE_OUT)    state_in = S_OUT;
               else if (mode_ff == MODE_FAST) state_in = S_FAST;
               else                          state_in = S_SQ;
            end
         end
         S_FAST: state_in = S_OUT;
         S_SQ:   if (sq_res.done) state_in = S_RT;
         S_RT:   if (rt_res.done) state_in = S_OUT;
         S_OUT:  if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         mode_ff     <= MODE_OFF;
         phase_ff    <= '0;
         sq_start_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         sq_start_ff <= req_acc && mode_ff != MODE_OFF && mode_ff != MODE_FAST &&
                        phase_in == PHASE_OUT;
         if (csr_valid && csr_ready) mode_ff <= csr_data;
         if (req_acc) phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         a_ff   <= i_abs[MAG_W-1:0];
         b_ff   <= q_abs[MAG_W-1:0];
         res_ff <= '0;
      end else if (state_ff == S_FAST) begin
         res_ff <= fast_sum[MAG_W-1:0];
      end else if (state_ff == S_RT && rt_res.done) begin
         res_ff <= rt_res.root;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (state_ff == S_OUT && out_free) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_OUT && out_free) rsp_env_ff <= res_ff;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {1'b0, rsp_env_ff};

   iqam_square u_square (
      .clock  (clock),
      .reset  (reset),
      .start  (sq_start_ff),
      .a_mag  (a_ff),
      .b_mag  (b_ff),
      .result (sq_res)
   );

   iqam_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_res.done),
      .radicand (sq_res.sum),
      .result   (rt_res)
   );

endmodule

FILE: hdl/iqam_checker.sv
// Port-level checks for the I/Q magnitude AM demodulator, bound to the top level.
`timescale 1ns / 1ps

module iqam_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp_tdata changed while stalled");

   a_env_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[15] == 1'b0 && rsp_tdata[14:0] <= 15'd23170))
      else $error("envelope out of range");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("outputs not cleared after reset");

endmodule

bind iq_magnitude_am_demodulator iqam_checker u_iqam_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: tb/sv/iq_magnitude_am_demodulator_test.sv
// Self-checking testbench for the I/Q magnitude AM demodulator.
`timescale 1ns / 1ps

module iq_magnitude_am_demodulator_test;
   import iqam_pkg::*;

   localparam logic [1:0] MODE_ROOT  = 2'd2;
   localparam logic [1:0] MODE_ROOT3 = 2'd3;   // decoded like the square-root mode

   localparam logic signed [15:0] S_MIN = 16'sh8000;
   localparam logic signed [15:0] S_MAX = 16'sh7FFF;
   localparam logic signed [15:0] S_NEG1 = 16'shFFFF;

   localparam int SETTLE_CYCLES = 40;
   localparam int CHUNK_ITEMS   = 56;
   localparam int LIMIT_CYCLES  = 500000;
   localparam logic [1:0] MODE_PLAN [8] = '{MODE_FAST, MODE_ROOT, MODE_OFF, MODE_ROOT3,
                                            MODE_ROOT, MODE_FAST, MODE_OFF, MODE_ROOT};

   typedef struct {
      logic [1:0]         mode;
      logic signed [15:0] i_s;
      logic signed [15:0] q_s;
      bit                 known;
      logic [14:0]        typed;
   } script_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_data = 2'd0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   logic [14:0] envelope_due [$];   // expected envelopes, oldest first
   logic [1:0]  mode_now = MODE_OFF;
   logic [1:0]  sample_phase = 2'd0;
   int          errors = 0;
   int          cycle_count = 0;
   int          calm_left = 0;
   int          hold_left = 0;
   logic        ready_next = 1'b1;
   logic [14:0] want;
   script_row_type script [$];

   iq_magnitude_am_demodulator dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic logic [14:0] envelope_for(logic [1:0] mode, logic signed [15:0] i_s,
                                                logic signed [15:0] q_s);
      int          hi;
      int          hq;
      int unsigned a;
      int unsigned b;
      int unsigned big;
      int unsigned lil;
      int unsigned rad;
      int unsigned rem;
      int unsigned root;
      hi = int'(i_s) >>> 1;
      hq = int'(q_s) >>> 1;
      a = (hi < 0) ? -hi : hi;
      b = (hq < 0) ? -hq : hq;
      if (mode == MODE_FAST) begin
         big = (a > b) ? a : b;
         lil = (a > b) ? b : a;
         return 15'(((31 * big) >> 5) + ((3 * lil) >> 3));
      end
      // bit-serial integer square root, two radicand bits per step
      rad = a * a + b * b;
      rem = 0;
      root = 0;
      for (int k = 0; k < 16; k++) begin
         root = root << 1;
         rem = (rem << 2) + (rad >> 30);
         rad = rad << 2;
         if (root < rem) begin
            root++;
            rem -= root;
            root++;
         end
      end
      return 15'(root >> 1);
   endfunction

   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return S_MIN;
         1: return S_MAX;
         2: return 16'sd0;
         3: return S_NEG1;
         4: return 16'sd1;
         5: return 16'($urandom_range(0, 31)) - 16'd16;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 5) begin
         calm_left = $urandom_range(20, 60);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // result side stall pattern: long ready runs, short stalls, a few long ones
   always @(posedge clock) begin
      int r;
      if (hold_left == 0) begin
         r = $urandom_range(0, 99);
         if (r < 60) begin
            ready_next = 1'b1;
            hold_left = $urandom_range(1, 30);
         end else if (r < 90) begin
            ready_next = 1'b0;
            hold_left = $urandom_range(1, 3);
         end else begin
            ready_next = 1'b0;
            hold_left = $urandom_range(10, 60);
         end
      end
      hold_left--;
      rsp_tready <= ready_next;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (envelope_due.size() == 0) begin
            $error("unexpected result item, envelope %0d", rsp_tdata[14:0]);
            errors++;
         end else begin
            want = envelope_due.pop_front();
            if (rsp_tdata[14:0] !== want) begin
               $error("envelope: expected %0d, got %0d", want, rsp_tdata[14:0]);
               errors++;
            end
            if (rsp_tdata[15] !== 1'b0) begin
               $error("tdata pad: expected 0, got %b", rsp_tdata[15]);
               errors++;
            end
         end
      end
   end

   task automatic send_item(logic signed [15:0] i_s, logic signed [15:0] q_s, bit known,
                            logic [14:0] typed);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata <= {q_s, i_s};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (req_tready !== 1'b1);
      // phase advances on every item, mode off included
      sample_phase = sample_phase + 2'd1;
      if (mode_now != MODE_OFF) begin
         if (sample_phase != PHASE_OUT)
            envelope_due.push_back('0);
         else if (known)
            envelope_due.push_back(typed);
         else
            envelope_due.push_back(envelope_for(mode_now, i_s, q_s));
      end
   endtask

   task automatic write_mode(logic [1:0] m);
      req_tvalid <= 1'b0;
      while (envelope_due.size() != 0) @(posedge clock);
      // mode-off items leave no trace in the queue, so let the pipe drain
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_data <= m;
      csr_valid <= 1'b1;
      do @(posedge clock); while (csr_ready !== 1'b1);
      mode_now = m;
      csr_valid <= 1'b0;
   endtask

   initial begin
      // mode off: consumed silently, phase still moves
      script.push_back('{MODE_OFF, S_MIN, S_MIN, 1'b0, 15'd0});
      script.push_back('{MODE_OFF, S_MAX, S_MAX, 1'b0, 15'd0});
      script.push_back('{MODE_FAST, 16'sh1234, 16'sh4321, 1'b1, 15'd0});
      script.push_back('{MODE_FAST, S_NEG1, S_NEG1, 1'b1, 15'd0});
      script.push_back('{MODE_FAST, S_MIN, S_MIN, 1'b1, 15'd22016});
      script.push_back('{MODE_FAST, S_MAX, S_MIN, 1'b1, 15'd0});
      script.push_back('{MODE_FAST, S_MIN, S_MAX, 1'b1, 15'd0});
      script.push_back('{MODE_FAST, S_MAX, S_MAX, 1'b1, 15'd0});
      script.push_back('{MODE_FAST, S_MAX, 16'sd0, 1'b1, 15'd15871});
      script.push_back('{MODE_FAST, 16'sd7, 16'sd9, 1'b1, 15'd0});
      script.push_back('{MODE_FAST, S_NEG1, 16'sd1, 1'b1, 15'd0});
      script.push_back('{MODE_FAST, S_MIN, 16'sd0, 1'b1, 15'd0});
      script.push_back('{MODE_FAST, 16'sd1234, -16'sd5678, 1'b0, 15'd0});
      script.push_back('{MODE_ROOT, 16'sd0, 16'sd0, 1'b1, 15'd0});
      script.push_back('{MODE_ROOT, S_MAX, S_MAX, 1'b1, 15'd0});
      script.push_back('{MODE_ROOT, S_MIN, S_MIN, 1'b1, 15'd0});
      script.push_back('{MODE_ROOT, S_MIN, S_MIN, 1'b1, 15'd23170});
      script.push_back('{MODE_ROOT, S_NEG1, 16'sd3, 1'b1, 15'd0});
      script.push_back('{MODE_ROOT, 16'sd100, -16'sd100, 1'b1, 15'd0});
      script.push_back('{MODE_ROOT, S_MAX, 16'sd0, 1'b1, 15'd0});
      // -1 halves to -1 under the arithmetic shift, so its magnitude is 1
      script.push_back('{MODE_ROOT, S_NEG1, 16'sd0, 1'b1, 15'd1});
      script.push_back('{MODE_ROOT3, 16'sd1, 16'sd1, 1'b1, 15'd0});
      script.push_back('{MODE_ROOT3, S_MIN, S_MAX, 1'b1, 15'd0});
      script.push_back('{MODE_ROOT3, -16'sd3000, 16'sd4000, 1'b1, 15'd0});
      script.push_back('{MODE_ROOT3, S_MAX, S_MAX, 1'b0, 15'd0});

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (script[n]) begin
         if (script[n].mode != mode_now) write_mode(script[n].mode);
         send_item(script[n].i_s, script[n].q_s, script[n].known, script[n].typed);
      end

      foreach (MODE_PLAN[c]) begin
         write_mode(MODE_PLAN[c]);
         repeat (CHUNK_ITEMS) send_item(pick_sample(), pick_sample(), 1'b0, 15'd0);
      end

      req_tvalid <= 1'b0;
      while (envelope_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
